[rtl/lkt_pkg.sv]
// ----------------------------------------------------------------------------
// lkt_pkg
// Shared types and constants for the lock key table: command and status codes,
// sequencer states and the request/response word layouts.
// ----------------------------------------------------------------------------
package lkt_pkg;

	localparam int KEY_SLOTS = 16;
	localparam int KEY_W     = 64;
	localparam int IDX_W     = (KEY_SLOTS > 1) ? $clog2(KEY_SLOTS) : 1;

	localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(KEY_SLOTS - 1);

	typedef enum logic [1:0] {
		CMD_OPEN       = 2'd0,
		CMD_CLOSE      = 2'd1,
		CMD_REGISTER   = 2'd2,
		CMD_UNREGISTER = 2'd3
	} cmd_e;

	typedef enum logic [2:0] {
		ST_OK        = 3'd0,
		ST_UNKNOWN   = 3'd1,
		ST_DUPLICATE = 3'd2,
		ST_FULL      = 3'd3,
		ST_NOT_FOUND = 3'd4,
		ST_ZERO_KEY  = 3'd5
	} status_e;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FINISH
	} state_e;

	typedef struct packed {
		logic [1:0]       command;
		logic [KEY_W-1:0] key_value;
	} req_t;

	typedef struct packed {
		logic [2:0] status;
		logic       lock_open;
	} rsp_t;

endpackage

[rtl/lock_key_table.sv]
// ----------------------------------------------------------------------------
// lock_key_table
// Access-key table with a lock-open flag. Open, register and unregister with a
// nonzero key scan the slots one per cycle through a single 64-bit comparator, then update the table/flag.
// ----------------------------------------------------------------------------
//
//  channel | signals                 | word
//  --------+-------------------------+------------------------------
//  req     | req_valid, req_ready    | command, key_value (req_t)
//  rsp     | rsp_valid, rsp_ready    | status, lock_open (rsp_t)
//
//  open, register and unregister with a nonzero key scan every slot before the
//  response, one slot compared per cycle by the shared key comparator. close and
//  zero-key commands skip the scan and go straight to the finish state.
//  req_ready is high only while the sequencer is idle; the response register
//  holds a word until taken, and a finished command waits in place for it.
//  reset empties every slot (per-slot valid bits) and closes the lock.
//
module lock_key_table (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_ready,
	input  lkt_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_ready,
	output lkt_pkg::rsp_t rsp
);

	lkt_pkg::state_e state_q, state_d;

	logic [lkt_pkg::KEY_W-1:0]     key_store_q [lkt_pkg::KEY_SLOTS];
	logic [lkt_pkg::KEY_SLOTS-1:0] key_valid_q;
	logic                          lock_q;

	lkt_pkg::cmd_e             cmd_q;
	logic [lkt_pkg::KEY_W-1:0] key_q;
	logic [lkt_pkg::IDX_W-1:0] idx_q;
	logic                      hit_q;
	logic [lkt_pkg::IDX_W-1:0] hit_idx_q;
	logic                      free_q;
	logic [lkt_pkg::IDX_W-1:0] free_idx_q;

	logic          rsp_valid_q;
	lkt_pkg::rsp_t rsp_q;

	logic               accept;
	logic               skip_scan;
	logic               slot_match;
	logic               slot_free;
	logic               finish_go;
	logic               wr_en;
	logic               clr_en;
	logic               lock_d;
	lkt_pkg::status_e   status_d;

	assign accept    = req_valid && req_ready;
	// close and zero keys never need the table
	assign skip_scan = (lkt_pkg::cmd_e'(req.command) == lkt_pkg::CMD_CLOSE) ||
		(req.key_value == '0);

	// the shared comparator: one slot a cycle
	assign slot_free  = !key_valid_q[idx_q];
	assign slot_match = key_valid_q[idx_q] && (key_store_q[idx_q] == key_q);

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		finish_go = 1'b0;
		wr_en     = 1'b0;
		clr_en    = 1'b0;
		lock_d    = lock_q;
		status_d  = lkt_pkg::ST_OK;
		unique case (state_q)
			lkt_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					state_d = skip_scan ? lkt_pkg::S_FINISH : lkt_pkg::S_SCAN;
				end
			end
			lkt_pkg::S_SCAN: begin
				if (idx_q == lkt_pkg::LAST_IDX) begin
					state_d = lkt_pkg::S_FINISH;
				end
			end
			lkt_pkg::S_FINISH: begin
				finish_go = !rsp_valid_q || rsp_ready;
				if (cmd_q == lkt_pkg::CMD_CLOSE) begin
					lock_d = 1'b0;
				end else if (key_q == '0) begin
					status_d = lkt_pkg::ST_ZERO_KEY;
				end else begin
					unique case (cmd_q)
						lkt_pkg::CMD_OPEN: begin
							if (hit_q) begin
								lock_d = 1'b1;
							end else begin
								status_d = lkt_pkg::ST_UNKNOWN;
							end
						end
						lkt_pkg::CMD_REGISTER: begin
							if (hit_q) begin
								status_d = lkt_pkg::ST_DUPLICATE;
							end else if (free_q) begin
								wr_en = finish_go;
							end else begin
								status_d = lkt_pkg::ST_FULL;
							end
						end
						lkt_pkg::CMD_UNREGISTER: begin
							if (hit_q) begin
								clr_en = finish_go;
							end else begin
								status_d = lkt_pkg::ST_NOT_FOUND;
							end
						end
						default: begin
							lock_d = 1'b0;
						end
					endcase
				end
				if (finish_go) begin
					state_d = lkt_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = lkt_pkg::S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= lkt_pkg::S_IDLE;
			key_valid_q <= '0;
			lock_q      <= 1'b0;
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			hit_q       <= 1'b0;
			free_q      <= 1'b0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				idx_q  <= '0;
				hit_q  <= 1'b0;
				free_q <= 1'b0;
			end else if (state_q == lkt_pkg::S_SCAN) begin
				idx_q <= idx_q + 1'b1;
				if (slot_match && !hit_q) begin
					hit_q <= 1'b1;
				end
				// lowest empty slot wins
				if (slot_free && !free_q) begin
					free_q <= 1'b1;
				end
			end
			if (wr_en) begin
				key_valid_q[free_idx_q] <= 1'b1;
			end
			if (clr_en) begin
				key_valid_q[hit_idx_q] <= 1'b0;
			end
			if (finish_go) begin
				lock_q      <= lock_d;
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers, no reset
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= lkt_pkg::cmd_e'(req.command);
			key_q <= req.key_value;
		end
		if (state_q == lkt_pkg::S_SCAN) begin
			if (slot_match && !hit_q) begin
				hit_idx_q <= idx_q;
			end
			if (slot_free && !free_q) begin
				free_idx_q <= idx_q;
			end
		end
		if (wr_en) begin
			key_store_q[free_idx_q] <= key_q;
		end
		if (finish_go) begin
			rsp_q.status    <= status_d;
			rsp_q.lock_open <= lock_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// the word on offer always reflects the current lock state
	a_rsp_lock: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q |-> (rsp_q.lock_open == lock_q))
		else $error("response lock bit differs from lock flag");

	// a stored key fills exactly one more slot
	a_reg_fill: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> ($countones(key_valid_q) == $past($countones(key_valid_q)) + 1))
		else $error("register did not fill exactly one slot");

	// a scan always starts from the first slot
	a_scan_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !skip_scan) |=> (state_q == lkt_pkg::S_SCAN && idx_q == '0))
		else $error("scan did not start at slot zero");

	// close always leaves the lock shut
	a_close: assert property (@(posedge clk) disable iff (!arst_n)
		(finish_go && cmd_q == lkt_pkg::CMD_CLOSE) |=> !lock_q)
		else $error("lock still open after close");

endmodule

[test/lock_key_table_tb.sv]
// ----------------------------------------------------------------------------
// lock_key_table_tb
// Self-checking bench for the lock key table. A short table of directed words
// covers the zero key, unknown and duplicate keys, a full table and the close
// command. Random words drawn mostly from a small key pool then follow, with
// idling on both sides and one long response hold-off. Every response is
// compared with an in-order queue fed by the directed rows' expected words or by a behavioural table model.
// ----------------------------------------------------------------------------
module lock_key_table_tb;

	localparam int STALL_LIMIT  = 4000;
	localparam int HOLD_CYCLES  = 300;
	localparam int POOL_SIZE    = 24;
	localparam int RANDOM_WORDS = 600;
	localparam int PLAN_ROWS    = 21;

	typedef struct {
		lkt_pkg::cmd_e             cmd;
		logic [lkt_pkg::KEY_W-1:0] key;
		int                        reps;
		bit                        typed;
		lkt_pkg::status_e          st;
		bit                        lock_after;
	} plan_row_t;

	logic          clk;
	logic          arst_n;
	logic          req_valid;
	logic          req_ready;
	lkt_pkg::req_t req;
	logic          rsp_valid;
	logic          rsp_ready;
	lkt_pkg::rsp_t rsp;

	// model of the table contents and the lock
	logic [lkt_pkg::KEY_W-1:0] held_keys [lkt_pkg::KEY_SLOTS];
	logic                      lock_is_open;

	lkt_pkg::rsp_t             awaited_rsp [$];
	logic [lkt_pkg::KEY_W-1:0] key_pool [POOL_SIZE];
	plan_row_t                 plan [PLAN_ROWS];
	int                        errors = 0;
	int                        rsp_count = 0;
	int                        quiet_cycles = 0;
	int                        send_idle_pct = 0;
	int                        rcv_idle_pct = 0;
	bit                        hold_rsp = 1'b0;

	lock_key_table dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic int slot_holding(logic [lkt_pkg::KEY_W-1:0] k);
		int i;
		for (i = 0; i < lkt_pkg::KEY_SLOTS; i++) begin
			if (held_keys[i] == k) return i;
		end
		return -1;
	endfunction

	function automatic lkt_pkg::rsp_t lock_outcome(lkt_pkg::req_t w);
		lkt_pkg::rsp_t r;
		int            hit;
		int            spare;
		r.status = lkt_pkg::ST_OK;
		hit = slot_holding(w.key_value);
		spare = slot_holding('0);
		if (w.command == lkt_pkg::CMD_CLOSE) begin
			lock_is_open = 1'b0;
		end else if (w.key_value == '0) begin
			r.status = lkt_pkg::ST_ZERO_KEY;
		end else begin
			case (w.command)
				lkt_pkg::CMD_OPEN: begin
					if (hit >= 0) lock_is_open = 1'b1;
					else r.status = lkt_pkg::ST_UNKNOWN;
				end
				lkt_pkg::CMD_REGISTER: begin
					if (hit >= 0) r.status = lkt_pkg::ST_DUPLICATE;
					else if (spare >= 0) held_keys[spare] = w.key_value;
					else r.status = lkt_pkg::ST_FULL;
				end
				default: begin
					if (hit >= 0) held_keys[hit] = '0;
					else r.status = lkt_pkg::ST_NOT_FOUND;
				end
			endcase
		end
		r.lock_open = lock_is_open;
		return r;
	endfunction

	function automatic logic [lkt_pkg::KEY_W-1:0] fresh_key();
		logic [lkt_pkg::KEY_W-1:0] k;
		k = {$urandom, $urandom};
		if (k == '0) k = 64'h1;
		return k;
	endfunction

	function automatic lkt_pkg::req_t random_word();
		lkt_pkg::req_t w;
		int            r;
		r = $urandom_range(99);
		w.command = (r < 30) ? lkt_pkg::CMD_OPEN : (r < 40) ? lkt_pkg::CMD_CLOSE :
			(r < 75) ? lkt_pkg::CMD_REGISTER : lkt_pkg::CMD_UNREGISTER;
		r = $urandom_range(99);
		if (r < 4) w.key_value = '0;
		else if (r < 10) w.key_value = fresh_key();
		else if (r < 12) w.key_value = '1;
		else w.key_value = key_pool[$urandom_range(POOL_SIZE-1)];
		return w;
	endfunction

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	// called at a falling edge, returns at the falling edge after acceptance
	task automatic offer(input lkt_pkg::req_t w, input bit typed,
		input lkt_pkg::rsp_t typed_rsp);
		lkt_pkg::rsp_t want;
		while ($urandom_range(99) < send_idle_pct) begin
			req_valid <= 1'b0;
			@(negedge clk);
		end
		want = lock_outcome(w);
		awaited_rsp.push_back(typed ? typed_rsp : want);
		req       <= w;
		req_valid <= 1'b1;
		@(posedge clk);
		while (!req_ready) @(posedge clk);
		@(negedge clk);
	endtask

	// response side: random ready, with one long hold-off on request
	initial begin
		rsp_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_rsp) begin
				rsp_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				hold_rsp = 1'b0;
			end
			rsp_ready <= ($urandom_range(99) >= rcv_idle_pct);
		end
	end

	always @(posedge clk) begin
		lkt_pkg::rsp_t want;
		if (rsp_valid && rsp_ready) begin
			if (awaited_rsp.size() == 0) begin
				report($sformatf("response %0d arrived with none awaited", rsp_count));
			end else begin
				want = awaited_rsp.pop_front();
				if (rsp.status !== want.status)
					report($sformatf("response %0d status %0d, want %0d",
						rsp_count, rsp.status, want.status));
				if (rsp.lock_open !== want.lock_open)
					report($sformatf("response %0d lock_open %0b, want %0b",
						rsp_count, rsp.lock_open, want.lock_open));
			end
			rsp_count++;
		end
	end

	always @(posedge clk) begin
		if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles = 0;
		else quiet_cycles++;
		if (quiet_cycles >= STALL_LIMIT) begin
			$display("lock_key_table_tb NOT OK");
			$finish;
		end
	end

	initial begin
		lkt_pkg::req_t w;
		lkt_pkg::rsp_t t;
		int            r;
		int            n;
		int            p;
		int            j;
		arst_n    = 1'b0;
		req_valid = 1'b0;
		req       = '0;
		lock_is_open = 1'b0;
		for (j = 0; j < lkt_pkg::KEY_SLOTS; j++) held_keys[j] = '0;
		for (j = 0; j < POOL_SIZE; j++) key_pool[j] = fresh_key();

		plan = '{
			'{lkt_pkg::CMD_OPEN,       64'h1, 1, 1'b1, lkt_pkg::ST_UNKNOWN,   1'b0},
			'{lkt_pkg::CMD_CLOSE,      64'h0, 1, 1'b1, lkt_pkg::ST_OK,        1'b0},
			'{lkt_pkg::CMD_OPEN,       64'h0, 1, 1'b1, lkt_pkg::ST_ZERO_KEY,  1'b0},
			'{lkt_pkg::CMD_REGISTER,   64'h0, 1, 1'b1, lkt_pkg::ST_ZERO_KEY,  1'b0},
			'{lkt_pkg::CMD_UNREGISTER, 64'h0, 1, 1'b1, lkt_pkg::ST_ZERO_KEY,  1'b0},
			'{lkt_pkg::CMD_UNREGISTER, '1,    1, 1'b1, lkt_pkg::ST_NOT_FOUND, 1'b0},
			'{lkt_pkg::CMD_REGISTER,   '1,    1, 1'b1, lkt_pkg::ST_OK,        1'b0},
			'{lkt_pkg::CMD_REGISTER,   '1,    1, 1'b1, lkt_pkg::ST_DUPLICATE, 1'b0},
			'{lkt_pkg::CMD_OPEN,       '1,    1, 1'b1, lkt_pkg::ST_OK,        1'b1},
			'{lkt_pkg::CMD_OPEN,       '1,    1, 1'b1, lkt_pkg::ST_OK,        1'b1},
			'{lkt_pkg::CMD_OPEN,       64'h8000_0000_0000_0000, 1, 1'b1,
				lkt_pkg::ST_UNKNOWN, 1'b1},
			// fill every remaining slot
			'{lkt_pkg::CMD_REGISTER,   64'h8000_0000_0000_0000, lkt_pkg::KEY_SLOTS-1,
				1'b0, lkt_pkg::ST_OK, 1'b1},
			'{lkt_pkg::CMD_REGISTER,   64'h1, 1, 1'b1, lkt_pkg::ST_FULL,      1'b1},
			'{lkt_pkg::CMD_UNREGISTER, '1,    1, 1'b1, lkt_pkg::ST_OK,        1'b1},
			'{lkt_pkg::CMD_REGISTER,   64'h5555_5555_aaaa_aaaa, 1, 1'b1,
				lkt_pkg::ST_OK, 1'b1},
			'{lkt_pkg::CMD_REGISTER,   64'h1, 1, 1'b1, lkt_pkg::ST_FULL,      1'b1},
			'{lkt_pkg::CMD_CLOSE,      '1,    1, 1'b1, lkt_pkg::ST_OK,        1'b0},
			'{lkt_pkg::CMD_OPEN,       64'h5555_5555_aaaa_aaaa, 1, 1'b1,
				lkt_pkg::ST_OK, 1'b1},
			'{lkt_pkg::CMD_UNREGISTER, 64'h5555_5555_aaaa_aaaa, 1, 1'b1,
				lkt_pkg::ST_OK, 1'b1},
			'{lkt_pkg::CMD_OPEN,       64'h5555_5555_aaaa_aaaa, 1, 1'b1,
				lkt_pkg::ST_UNKNOWN, 1'b1},
			'{lkt_pkg::CMD_UNREGISTER, 64'h8000_0000_0000_0000, 1, 1'b0,
				lkt_pkg::ST_OK, 1'b1}
		};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		send_idle_pct = 9;
		rcv_idle_pct  = 61;
		for (r = 0; r < PLAN_ROWS; r++) begin
			for (n = 0; n < plan[r].reps; n++) begin
				w.command   = plan[r].cmd;
				w.key_value = plan[r].key + n;
				t.status    = plan[r].st;
				t.lock_open = plan[r].lock_after;
				offer(w, plan[r].typed, t);
			end
		end

		for (p = 0; p < 3; p++) begin
			send_idle_pct = (p == 0) ? 9 : (p == 1) ? 61 : 0;
			rcv_idle_pct  = (p == 0) ? 61 : (p == 1) ? 9 : 0;
			// long response hold-off so the block backs up onto its input
			if (p == 2) hold_rsp = 1'b1;
			for (n = 0; n < RANDOM_WORDS; n++) begin
				// swap out pool keys that are not stored, keeps fresh content coming
				if ($urandom_range(99) < 3) begin
					j = $urandom_range(POOL_SIZE-1);
					if (slot_holding(key_pool[j]) < 0) key_pool[j] = fresh_key();
				end
				offer(random_word(), 1'b0, '0);
			end
		end
		req_valid <= 1'b0;

		while (awaited_rsp.size() != 0) @(posedge clk);
		repeat (lkt_pkg::KEY_SLOTS + 8) @(posedge clk);
		if (errors == 0) begin
			$display("lock_key_table_tb OK");
		end else begin
			$display("lock_key_table_tb NOT OK");
		end
		$finish;
	end

endmodule

[files.f]
rtl/lkt_pkg.sv
rtl/lock_key_table.sv
test/lock_key_table_tb.sv
